>>> rtl/twla_pkg.sv
// Shared constants and types for the time-weighted log averager.
// No dependencies; used by time_weighted_log_averager_unit.
package twla_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned TPS_RECIP_SHIFT  = 24;
    localparam int unsigned TPS_RECIP        =
        ((1 << TPS_RECIP_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
    localparam int unsigned MAX_CLOSES       = 4;
    localparam int unsigned CLOSE_W          = $clog2(MAX_CLOSES);
    localparam int unsigned DIV_STEPS        = 32;
    localparam int unsigned DIV_CNT_W        = $clog2(DIV_STEPS);
    localparam logic [15:0] RECORD_INTERVAL_RST = 16'd60;
    localparam logic [15:0] ONPROP_MAX       = 16'd127;

    typedef enum logic [1:0] {
        KIND_ONPROP   = 2'd0,
        KIND_SETPOINT = 2'd1,
        KIND_TEMP     = 2'd2
    } t_kind;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_EVAL  = 7'b000_0010,
        S_MUL   = 7'b000_0100,
        S_ACC   = 7'b000_1000,
        S_CLOSE = 7'b001_0000,
        S_DIV   = 7'b010_0000,
        S_EMIT  = 7'b100_0000
    } t_state;

endpackage

>>> rtl/time_weighted_log_averager_unit.sv
// Time-weighted log averager: weighted sums, interval averages, change-only on/setpoint records.
// Depends on twla_pkg (constants, kind codes, state type).
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: temperature, on_proportion, setpoint, ticks
//  m_*      out  m_tvalid/m_tready    m_tdata: record_value; m_tuser: kind; m_tlast
//  cfg      in   i_cfg_valid/o_cfg_ready  i_cfg_data: record_interval
//
// A word without an interval close passes, from accept to the next accept, through the evaluate
// state and three multiply/accumulate pairs. Each close adds three rounds of load, 32
// restoring-divider steps and emit, plus any output stall; each further pass over leftover
// seconds repeats evaluate and the pairs. Ticks become seconds by a reciprocal multiply at accept.
// s_tready and o_cfg_ready are high only in idle; a record stalled on m_tready holds the sequencer.
// Reset (synchronous, active low) clears sums, last records, and sets interval to 60.
module time_weighted_log_averager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] temperature, [22:16] on_proportion, [38:23] setpoint,
    // [50:39] elapsed_ticks, [55:51] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] record_value
    output logic [15:0] m_tdata,
    // [1:0] record_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    twla_pkg::t_state r_state, n_state;
    twla_pkg::t_kind  r_kind, n_kind;

    logic [15:0] r_cfg;
    logic [31:0] r_temp_sum, n_temp_sum;
    logic [22:0] r_onprop_sum, n_onprop_sum;
    logic [31:0] r_setpoint_sum, n_setpoint_sum;
    logic [16:0] r_seconds_sum, n_seconds_sum;
    logic [6:0]  r_last_onprop, n_last_onprop;
    logic [15:0] r_last_setpoint, n_last_setpoint;
    logic [twla_pkg::CLOSE_W-1:0] r_closes, n_closes;

    logic [15:0] r_t, r_s;
    logic [6:0]  r_p;
    logic [11:0] r_rem_secs, n_rem_secs;
    logic [11:0] r_part, n_part;
    logic        r_closing, n_closing;
    logic        r_last, n_last;
    logic [27:0] r_prod, n_prod;
    logic [15:0] r_avg, n_avg;

    logic [31:0] r_dq, n_dq;
    logic [15:0] r_dr, n_dr;
    logic [15:0] r_dvs, n_dvs;
    logic [twla_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic        r_m_tvalid, n_m_tvalid;
    logic [15:0] r_m_data, n_m_data;
    logic [1:0]  r_m_kind, n_m_kind;
    logic        r_m_last, n_m_last;

    logic [35:0] w_tick_prod;
    logic [15:0] w_ivl;
    logic [17:0] w_total;
    logic [16:0] w_gap;
    logic [11:0] w_part;
    logic [11:0] w_rem_after;
    logic [16:0] w_trial;
    logic        w_ge;
    logic [16:0] w_diff;
    logic [31:0] w_q_next;
    logic        w_div_done;
    logic [15:0] w_mul_a;
    logic [15:0] w_sat_max;
    logic [15:0] w_sat;
    logic        w_need;
    logic        w_slot_free;

    assign s_tready    = (r_state == twla_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == twla_pkg::S_IDLE);
    assign m_tvalid    = r_m_tvalid;
    assign m_tdata     = r_m_data;
    assign m_tuser     = r_m_kind;
    assign m_tlast     = r_m_last;

    // ticks to whole seconds, exact for every 12-bit tick count
    assign w_tick_prod = 36'(s_tdata[50:39]) * 36'(twla_pkg::TPS_RECIP);

    assign w_ivl       = (r_cfg == 16'd0) ? 16'd1 : r_cfg;
    assign w_total     = {1'b0, r_seconds_sum} + 18'(r_rem_secs);
    assign w_gap       = (17'(w_ivl) > r_seconds_sum) ? 17'(w_ivl) - r_seconds_sum : 17'd0;
    assign w_part      = (w_gap > 17'(r_rem_secs)) ? r_rem_secs : w_gap[11:0];
    assign w_rem_after = r_rem_secs - w_part;

    // restoring divider step
    assign w_trial    = {r_dr, r_dq[31]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign w_q_next   = {r_dq[30:0], w_ge};
    assign w_div_done = (r_cnt == twla_pkg::DIV_CNT_W'(twla_pkg::DIV_STEPS - 1));

    assign w_sat_max  = (r_kind == twla_pkg::KIND_ONPROP) ? twla_pkg::ONPROP_MAX : 16'hFFFF;
    assign w_sat      = (w_q_next > 32'(w_sat_max)) ? w_sat_max : w_q_next[15:0];

    assign w_slot_free = !r_m_tvalid || m_tready;

    always_comb begin
        unique case (r_kind)
            twla_pkg::KIND_ONPROP:   w_mul_a = 16'(r_p);
            twla_pkg::KIND_SETPOINT: w_mul_a = r_s;
            default:                 w_mul_a = r_t;
        endcase
    end

    always_comb begin
        unique case (r_kind)
            twla_pkg::KIND_ONPROP:   w_need = (r_avg[6:0] != r_last_onprop);
            twla_pkg::KIND_SETPOINT: w_need = (r_avg != r_last_setpoint);
            default:                 w_need = 1'b1;
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_kind          = r_kind;
        n_temp_sum      = r_temp_sum;
        n_onprop_sum    = r_onprop_sum;
        n_setpoint_sum  = r_setpoint_sum;
        n_seconds_sum   = r_seconds_sum;
        n_last_onprop   = r_last_onprop;
        n_last_setpoint = r_last_setpoint;
        n_closes        = r_closes;
        n_rem_secs      = r_rem_secs;
        n_part          = r_part;
        n_closing       = r_closing;
        n_last          = r_last;
        n_prod          = r_prod;
        n_avg           = r_avg;
        n_dq            = w_q_next;
        n_dr            = w_ge ? w_diff[15:0] : w_trial[15:0];
        n_dvs           = r_dvs;
        n_cnt           = r_cnt + 1'b1;
        n_m_tvalid      = r_m_tvalid && !m_tready;
        n_m_data        = r_m_data;
        n_m_kind        = r_m_kind;
        n_m_last        = r_m_last;

        unique case (r_state)
            twla_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    n_rem_secs = w_tick_prod[twla_pkg::TPS_RECIP_SHIFT +: 12];
                    n_closes   = '0;
                    n_state    = twla_pkg::S_EVAL;
                end
            end
            twla_pkg::S_EVAL: begin
                n_kind = twla_pkg::KIND_ONPROP;
                if (w_total >= 18'(w_ivl)) begin
                    n_closing     = 1'b1;
                    n_part        = w_part;
                    n_rem_secs    = w_rem_after;
                    n_seconds_sum = '0;
                    n_last        = (16'(w_rem_after) < w_ivl) ||
                                    (r_closes == twla_pkg::CLOSE_W'(twla_pkg::MAX_CLOSES - 1));
                end else begin
                    n_closing     = 1'b0;
                    n_part        = r_rem_secs;
                    n_seconds_sum = w_total[16:0];
                end
                n_state = twla_pkg::S_MUL;
            end
            twla_pkg::S_MUL: begin
                n_prod  = 28'(w_mul_a) * 28'(r_part);
                n_state = twla_pkg::S_ACC;
            end
            twla_pkg::S_ACC: begin
                unique case (r_kind)
                    twla_pkg::KIND_ONPROP: begin
                        n_onprop_sum = r_onprop_sum + r_prod[22:0];
                        n_kind       = twla_pkg::KIND_SETPOINT;
                        n_state      = twla_pkg::S_MUL;
                    end
                    twla_pkg::KIND_SETPOINT: begin
                        n_setpoint_sum = r_setpoint_sum + 32'(r_prod);
                        n_kind         = twla_pkg::KIND_TEMP;
                        n_state        = twla_pkg::S_MUL;
                    end
                    default: begin
                        n_temp_sum = r_temp_sum + 32'(r_prod);
                        n_kind     = twla_pkg::KIND_ONPROP;
                        n_state    = r_closing ? twla_pkg::S_CLOSE : twla_pkg::S_IDLE;
                    end
                endcase
            end
            twla_pkg::S_CLOSE: begin
                unique case (r_kind)
                    twla_pkg::KIND_ONPROP:   n_dq = 32'(r_onprop_sum);
                    twla_pkg::KIND_SETPOINT: n_dq = r_setpoint_sum;
                    default:                 n_dq = r_temp_sum;
                endcase
                n_dr    = '0;
                n_dvs   = w_ivl;
                n_cnt   = '0;
                n_state = twla_pkg::S_DIV;
            end
            twla_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_avg   = w_sat;
                    n_state = twla_pkg::S_EMIT;
                end
            end
            twla_pkg::S_EMIT: begin
                if (!w_need || w_slot_free) begin
                    if (w_need) begin
                        n_m_tvalid = 1'b1;
                        n_m_data   = r_avg;
                        n_m_kind   = r_kind;
                        n_m_last   = (r_kind == twla_pkg::KIND_TEMP) && r_last;
                    end
                    unique case (r_kind)
                        twla_pkg::KIND_ONPROP: begin
                            n_last_onprop = r_avg[6:0];
                            n_kind        = twla_pkg::KIND_SETPOINT;
                            n_state       = twla_pkg::S_CLOSE;
                        end
                        twla_pkg::KIND_SETPOINT: begin
                            n_last_setpoint = r_avg;
                            n_kind          = twla_pkg::KIND_TEMP;
                            n_state         = twla_pkg::S_CLOSE;
                        end
                        default: begin
                            n_temp_sum     = '0;
                            n_onprop_sum   = '0;
                            n_setpoint_sum = '0;
                            n_kind         = twla_pkg::KIND_ONPROP;
                            n_closes       = r_closes + 1'b1;
                            // leftover seconds are re-evaluated unless the close limit is hit
                            n_state        = ((r_rem_secs == 12'd0) ||
                                              (r_closes ==
                                               twla_pkg::CLOSE_W'(twla_pkg::MAX_CLOSES - 1)))
                                             ? twla_pkg::S_IDLE : twla_pkg::S_EVAL;
                        end
                    endcase
                end
            end
            default: n_state = twla_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= twla_pkg::S_IDLE;
            r_kind          <= twla_pkg::KIND_ONPROP;
            r_cfg           <= twla_pkg::RECORD_INTERVAL_RST;
            r_temp_sum      <= '0;
            r_onprop_sum    <= '0;
            r_setpoint_sum  <= '0;
            r_seconds_sum   <= '0;
            r_last_onprop   <= '0;
            r_last_setpoint <= '0;
            r_closes        <= '0;
            r_m_tvalid      <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_kind          <= n_kind;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            r_temp_sum      <= n_temp_sum;
            r_onprop_sum    <= n_onprop_sum;
            r_setpoint_sum  <= n_setpoint_sum;
            r_seconds_sum   <= n_seconds_sum;
            r_last_onprop   <= n_last_onprop;
            r_last_setpoint <= n_last_setpoint;
            r_closes        <= n_closes;
            r_m_tvalid      <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_t <= s_tdata[15:0];
            r_p <= s_tdata[22:16];
            r_s <= s_tdata[38:23];
        end
        r_rem_secs <= n_rem_secs;
        r_part     <= n_part;
        r_closing  <= n_closing;
        r_last     <= n_last;
        r_prod     <= n_prod;
        r_avg      <= n_avg;
        r_dq       <= n_dq;
        r_dr       <= n_dr;
        r_dvs      <= n_dvs;
        r_cnt      <= n_cnt;
        r_m_data   <= n_m_data;
        r_m_kind   <= n_m_kind;
        r_m_last   <= n_m_last;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while sequencer busy");

    a_onprop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == twla_pkg::KIND_ONPROP) |-> (m_tdata[15:7] == 9'd0))
        else $error("on-percentage record out of range");

    a_last_is_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == twla_pkg::KIND_TEMP))
        else $error("last record of run is not a temperature record");

    a_sums_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twla_pkg::S_EMIT && r_kind == twla_pkg::KIND_TEMP && w_slot_free)
        |=> (r_temp_sum == 32'd0 && r_onprop_sum == 23'd0 && r_setpoint_sum == 32'd0))
        else $error("sums not cleared after interval close");

endmodule
